@@ hdl/text_console_writer_defines.svh @@
// Assertion macros for the checker file of the text console writer.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text console writer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text console writer check failed");

`endif

@@ hdl/tcw_pkg.sv @@
// Package with the screen geometry, field widths, codes and shared types.
`timescale 1ns / 1ps
package tcw_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 4;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam int ACTION_W       = 2;
    localparam int CHAR_W         = 8;
    localparam int NEW_COL_W      = 7;
    localparam int NEW_ROW_W      = 5;
    localparam int CELL_INDEX_W   = 11;
    localparam int CURSOR_INDEX_W = 11;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_SET   = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    // Tab target column for every cursor column: the next multiple of TAB_STOP.
    typedef logic [7:0] tab_table_t [COLUMNS];

    function automatic tab_table_t build_tab_table();
        tab_table_t t;
        for (int i = 0; i < COLUMNS; i++) begin
            t[i] = 8'(i + TAB_STOP - ((i + TAB_STOP) % TAB_STOP));
        end
        return t;
    endfunction

    localparam tab_table_t TAB_TABLE = build_tab_table();

    // Command from the sequencer to the cursor unit.
    typedef struct packed {
        logic                 apply;
        action_t              action;
        logic [CHAR_W-1:0]    char_code;
        logic [NEW_COL_W-1:0] new_col;
        logic [NEW_ROW_W-1:0] new_row;
    } cursor_cmd_t;

    // Status from the cursor unit, for the cursor as it stands now.
    typedef struct packed {
        logic [ADDR_W-1:0] index;
        logic              put_write;
        logic              put_scroll;
    } cursor_stat_t;

endpackage

@@ hdl/tcw_cmd_if.sv @@
// Command channel interface: one console action per transaction.
`timescale 1ns / 1ps
interface tcw_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [tcw_pkg::ACTION_W-1:0]     action;
    logic [tcw_pkg::CHAR_W-1:0]       char_code;
    logic [tcw_pkg::NEW_COL_W-1:0]    new_col;
    logic [tcw_pkg::NEW_ROW_W-1:0]    new_row;
    logic [tcw_pkg::CELL_INDEX_W-1:0] cell_index;

    modport source (output valid, action, char_code, new_col, new_row, cell_index,
                    input ready);
    modport sink (input valid, action, char_code, new_col, new_row, cell_index,
                  output ready);
endinterface

@@ hdl/tcw_rsp_if.sv @@
// Response channel interface: one result per command transaction.
`timescale 1ns / 1ps
interface tcw_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [tcw_pkg::CURSOR_INDEX_W-1:0] cursor_index;
    logic [tcw_pkg::CHAR_W-1:0]         cell_char;
    logic                               scrolled;

    modport source (output valid, cursor_index, cell_char, scrolled, input ready);
    modport sink (input valid, cursor_index, cell_char, scrolled, output ready);
endinterface

@@ hdl/tcw_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/tcw_cursor.sv @@
// Cursor unit: holds the cursor and works out its next position for each action.
`timescale 1ns / 1ps
module tcw_cursor (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcw_pkg::cursor_cmd_t  cmd,
    output tcw_pkg::cursor_stat_t stat
);

    logic [tcw_pkg::COL_W-1:0] col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0] row_reg, row_next;

    logic       at_last_col;
    logic       at_last_row;
    logic [7:0] tab_target;
    logic       is_newline;
    logic       is_tab;
    logic       is_plain;
    logic       need_newline;

    assign at_last_col = (col_reg == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
    assign at_last_row = (row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
    assign tab_target  = tcw_pkg::TAB_TABLE[col_reg];
    assign is_newline  = (cmd.char_code == tcw_pkg::CH_NEWLINE);
    assign is_tab      = (cmd.char_code == tcw_pkg::CH_TAB);
    assign is_plain    = !is_newline && !is_tab;

    // A tab that lands on or past the right edge behaves as a newline.
    assign need_newline = is_newline
                        || (is_tab && (tab_target >= 8'(tcw_pkg::COLUMNS)))
                        || (is_plain && at_last_col);

    assign stat.index = tcw_pkg::ADDR_W'(row_reg) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)
                      + tcw_pkg::ADDR_W'(col_reg);
    assign stat.put_write  = is_plain;
    assign stat.put_scroll = need_newline && at_last_row;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.apply)
        begin
            unique case (cmd.action)
                tcw_pkg::ACT_PUT:
                begin
                    if (need_newline)
                    begin
                        col_next = '0;
                        if (!at_last_row)
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else if (is_tab)
                    begin
                        col_next = tcw_pkg::COL_W'(tab_target);
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
                tcw_pkg::ACT_CLEAR:
                begin
                    col_next = '0;
                    row_next = '0;
                end
                tcw_pkg::ACT_SET:
                begin
                    if (8'(cmd.new_col) >= 8'(tcw_pkg::COLUMNS))
                    begin
                        col_next = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
                    end
                    else
                    begin
                        col_next = tcw_pkg::COL_W'(cmd.new_col);
                    end
                    if (7'(cmd.new_row) >= 7'(tcw_pkg::ROWS))
                    begin
                        row_next = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
                    end
                    else
                    begin
                        row_next = tcw_pkg::ROW_W'(cmd.new_row);
                    end
                end
                tcw_pkg::ACT_READ:
                begin
                    col_next = col_reg;
                end
                default:
                begin
                    col_next = col_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ hdl/text_console_writer.sv @@
// Top level of the text console writer: sequencer, cursor unit, screen RAM and result register.
//
//   channel | dir | payload                                   | handshake
//   cmd     | in  | action, char_code, new_col, new_row,      | valid/ready
//           |     | cell_index                                |
//   rsp     | out | cursor_index, cell_char, scrolled         | valid/ready
//
// Put (without a scroll) and set cursor go from idle straight to the result state;
// read cell first passes a capture state, unless the index lies off the screen.
// Clear screen, and a put that scrolls, sweep the screen RAM one cell per
// cycle through its single write port.
// After reset a clearing pass over all ROWS*COLUMNS cells fills the RAM with spaces
// before the first command is taken.
// A command may be accepted while the previous result still waits on rsp;
// its own result then waits until that slot frees up.
`timescale 1ns / 1ps
module text_console_writer (
    input logic       clk,
    input logic       rst_n,
    tcw_cmd_if.sink   cmd,
    tcw_rsp_if.source rsp
);

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_CAPTURE,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;

    logic [tcw_pkg::ADDR_W-1:0] cnt_reg, cnt_next;
    logic                       copy_mode_reg, copy_mode_next;
    logic                       report_reg, report_next;
    logic                       wr_en_reg, wr_en_next;
    logic [tcw_pkg::ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic [tcw_pkg::CHAR_W-1:0] wr_data_reg, wr_data_next;
    logic                       wr_from_ram_reg, wr_from_ram_next;
    logic [tcw_pkg::CHAR_W-1:0] cell_reg, cell_next;
    logic                       scrolled_reg, scrolled_next;

    logic                               rsp_valid_reg, rsp_valid_next;
    logic [tcw_pkg::CURSOR_INDEX_W-1:0] rsp_index_reg, rsp_index_next;
    logic [tcw_pkg::CHAR_W-1:0]         rsp_char_reg, rsp_char_next;
    logic                               rsp_scrolled_reg, rsp_scrolled_next;

    logic                       rd_en;
    logic [tcw_pkg::ADDR_W-1:0] rd_addr;
    logic [tcw_pkg::CHAR_W-1:0] rd_data;
    logic [tcw_pkg::CHAR_W-1:0] wr_data;

    logic                  accept;
    logic                  copy_step;
    logic                  read_in_range;
    tcw_pkg::action_t      action;
    tcw_pkg::cursor_cmd_t  cur_cmd;
    tcw_pkg::cursor_stat_t cur_stat;

    // Ready stays low while a RAM write is pending so a read never races it.
    assign cmd.ready = (state_reg == S_IDLE) && !wr_en_reg;
    assign accept    = cmd.valid && cmd.ready;
    assign action    = tcw_pkg::action_t'(cmd.action);

    assign read_in_range = (int'(cmd.cell_index) < tcw_pkg::CELLS);
    assign copy_step     = copy_mode_reg
                         && (int'(cnt_reg) < (tcw_pkg::CELLS - tcw_pkg::COLUMNS));

    assign cur_cmd.apply     = accept;
    assign cur_cmd.action    = action;
    assign cur_cmd.char_code = cmd.char_code;
    assign cur_cmd.new_col   = cmd.new_col;
    assign cur_cmd.new_row   = cmd.new_row;

    tcw_cursor u_cursor (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cur_cmd),
        .stat (cur_stat)
    );

    // Copied cells come straight from the read data of the cycle before.
    assign wr_data = wr_from_ram_reg ? rd_data : wr_data_reg;

    tcw_ram #(
        .WIDTH(tcw_pkg::CHAR_W),
        .DEPTH(tcw_pkg::CELLS)
    ) u_screen_ram (
        .clk  (clk),
        .we   (wr_en_reg),
        .waddr(wr_addr_reg),
        .wdata(wr_data),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        copy_mode_next    = copy_mode_reg;
        report_next       = report_reg;
        wr_en_next        = 1'b0;
        wr_addr_next      = wr_addr_reg;
        wr_data_next      = wr_data_reg;
        wr_from_ram_next  = 1'b0;
        cell_next         = cell_reg;
        scrolled_next     = scrolled_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        rsp_index_next    = rsp_index_reg;
        rsp_char_next     = rsp_char_reg;
        rsp_scrolled_next = rsp_scrolled_reg;
        rd_en             = 1'b0;
        rd_addr           = cnt_reg + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);

        unique case (state_reg)
            S_SWEEP:
            begin
                // Scroll copies each cell from one row below; the last row and a
                // clear get spaces.
                wr_en_next   = 1'b1;
                wr_addr_next = cnt_reg;
                wr_data_next = tcw_pkg::CH_SPACE;
                if (copy_step)
                begin
                    rd_en            = 1'b1;
                    wr_from_ram_next = 1'b1;
                end
                if (int'(cnt_reg) == tcw_pkg::CELLS - 1)
                begin
                    cnt_next   = '0;
                    state_next = report_reg ? S_RESULT : S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cell_next     = '0;
                    scrolled_next = 1'b0;
                    state_next    = S_RESULT;
                    unique case (action)
                        tcw_pkg::ACT_PUT:
                        begin
                            if (cur_stat.put_write)
                            begin
                                wr_en_next   = 1'b1;
                                wr_addr_next = cur_stat.index;
                                wr_data_next = cmd.char_code;
                            end
                            if (cur_stat.put_scroll)
                            begin
                                scrolled_next  = 1'b1;
                                copy_mode_next = 1'b1;
                                report_next    = 1'b1;
                                state_next     = S_SWEEP;
                            end
                        end
                        tcw_pkg::ACT_CLEAR:
                        begin
                            copy_mode_next = 1'b0;
                            report_next    = 1'b1;
                            state_next     = S_SWEEP;
                        end
                        tcw_pkg::ACT_SET:
                        begin
                            state_next = S_RESULT;
                        end
                        tcw_pkg::ACT_READ:
                        begin
                            if (read_in_range)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = tcw_pkg::ADDR_W'(cmd.cell_index);
                                state_next = S_CAPTURE;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_CAPTURE:
            begin
                cell_next  = rd_data;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_index_next    = tcw_pkg::CURSOR_INDEX_W'(cur_stat.index);
                    rsp_char_next     = cell_reg;
                    rsp_scrolled_next = scrolled_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_SWEEP;
            cnt_reg          <= '0;
            copy_mode_reg    <= 1'b0;
            report_reg       <= 1'b0;
            wr_en_reg        <= 1'b0;
            wr_addr_reg      <= '0;
            wr_data_reg      <= '0;
            wr_from_ram_reg  <= 1'b0;
            cell_reg         <= '0;
            scrolled_reg     <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            rsp_index_reg    <= '0;
            rsp_char_reg     <= '0;
            rsp_scrolled_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            copy_mode_reg    <= copy_mode_next;
            report_reg       <= report_next;
            wr_en_reg        <= wr_en_next;
            wr_addr_reg      <= wr_addr_next;
            wr_data_reg      <= wr_data_next;
            wr_from_ram_reg  <= wr_from_ram_next;
            cell_reg         <= cell_next;
            scrolled_reg     <= scrolled_next;
            rsp_valid_reg    <= rsp_valid_next;
            rsp_index_reg    <= rsp_index_next;
            rsp_char_reg     <= rsp_char_next;
            rsp_scrolled_reg <= rsp_scrolled_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.cursor_index = rsp_index_reg;
    assign rsp.cell_char    = rsp_char_reg;
    assign rsp.scrolled     = rsp_scrolled_reg;

endmodule

@@ hdl/tcw_checker.sv @@
// Port-level checker for the text console writer, bound to the top level.
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"
module tcw_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cmd_valid,
    input logic                               cmd_ready,
    input logic                               rsp_valid,
    input logic                               rsp_ready,
    input logic [tcw_pkg::CURSOR_INDEX_W-1:0] rsp_cursor_index,
    input logic [tcw_pkg::CHAR_W-1:0]         rsp_cell_char,
    input logic                               rsp_scrolled
);

    // A result that is not taken stays offered.
    `TCW_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

    // The block is busy in the cycle after it takes a command.
    `TCW_ASSERT_NEXT(a_busy_after_cmd, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)

    // A scroll always leaves the cursor at the start of the last row.
    `TCW_ASSERT_IMPLY(a_scroll_cursor, clk, rst_n, rsp_valid && rsp_scrolled, int'(rsp_cursor_index) == ((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS) % 2048)

    // Only a read returns a character, and a read never scrolls.
    `TCW_ASSERT_IMPLY(a_scroll_no_char, clk, rst_n, rsp_valid && rsp_scrolled, rsp_cell_char == '0)

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_cursor_index(rsp.cursor_index),
    .rsp_cell_char   (rsp.cell_char),
    .rsp_scrolled    (rsp.scrolled)
);

@@ bench/tb.sv @@
// Self-checking testbench for the text console writer: screen writes, scrolling and cursor moves.
`timescale 1ns / 1ps
module tb;

    localparam int RANDOM_CMDS  = 1600;
    // A clear or a scrolling put sweeps the whole screen RAM.
    localparam int DRAIN_CYCLES = tcw_pkg::CELLS + 200;
    localparam int CLK_HALF     = 5;

    typedef struct {
        tcw_pkg::action_t                 action;
        logic [tcw_pkg::CHAR_W-1:0]       char_code;
        logic [tcw_pkg::NEW_COL_W-1:0]    new_col;
        logic [tcw_pkg::NEW_ROW_W-1:0]    new_row;
        logic [tcw_pkg::CELL_INDEX_W-1:0] cell_index;
    } console_cmd_t;

    typedef struct {
        logic [tcw_pkg::CURSOR_INDEX_W-1:0] cursor_index;
        logic [tcw_pkg::CHAR_W-1:0]         cell_char;
        logic                               scrolled;
    } console_rsp_t;

    logic clk;
    logic rst_n;

    tcw_cmd_if cmd_ch ();
    tcw_rsp_if rsp_ch ();

    text_console_writer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    console_cmd_t cmd_pending[$];
    console_rsp_t console_rsp_q[$];

    // Predicted screen contents and cursor.
    logic [tcw_pkg::CHAR_W-1:0] screen_mirror [tcw_pkg::CELLS];
    int unsigned                cur_col;
    int unsigned                cur_row;

    int total_cmds;
    int sent_cnt;
    int cmd_acc_cnt;
    int err_cnt;
    int put_cnt;
    int clear_cnt;
    int set_cnt;
    int read_cnt;
    int scroll_cnt;

    always #(CLK_HALF) clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Screen predictor
    // ------------------------------------------------------------------
    function automatic void blank_screen();
        for (int i = 0; i < tcw_pkg::CELLS; i++)
        begin
            screen_mirror[i] = tcw_pkg::CH_SPACE;
        end
        cur_col = 0;
        cur_row = 0;
    endfunction

    // Go to column 0 of the next row, scrolling up when leaving the last row.
    function automatic bit advance_line();
        cur_col = 0;
        if (cur_row + 1 >= tcw_pkg::ROWS)
        begin
            for (int i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLUMNS; i++)
            begin
                screen_mirror[i] = screen_mirror[i + tcw_pkg::COLUMNS];
            end
            for (int i = tcw_pkg::CELLS - tcw_pkg::COLUMNS; i < tcw_pkg::CELLS; i++)
            begin
                screen_mirror[i] = tcw_pkg::CH_SPACE;
            end
            cur_row = tcw_pkg::ROWS - 1;
            return 1'b1;
        end
        cur_row++;
        return 1'b0;
    endfunction

    function automatic bit put_to_screen(input logic [tcw_pkg::CHAR_W-1:0] ch);
        int unsigned col;
        if (ch == tcw_pkg::CH_NEWLINE)
        begin
            return advance_line();
        end
        if (ch == tcw_pkg::CH_TAB)
        begin
            col = cur_col + tcw_pkg::TAB_STOP;
            col -= col % tcw_pkg::TAB_STOP;
            if (col >= tcw_pkg::COLUMNS)
            begin
                return advance_line();
            end
            cur_col = col;
            return 1'b0;
        end
        screen_mirror[cur_row * tcw_pkg::COLUMNS + cur_col] = ch;
        if (cur_col + 1 >= tcw_pkg::COLUMNS)
        begin
            return advance_line();
        end
        cur_col++;
        return 1'b0;
    endfunction

    function automatic console_rsp_t predict_console(input console_cmd_t c);
        console_rsp_t r;
        r.cell_char = '0;
        r.scrolled  = 1'b0;
        case (c.action)
            tcw_pkg::ACT_PUT:
            begin
                r.scrolled = put_to_screen(c.char_code);
                put_cnt++;
            end
            tcw_pkg::ACT_CLEAR:
            begin
                blank_screen();
                clear_cnt++;
            end
            tcw_pkg::ACT_SET:
            begin
                cur_col = (c.new_col < tcw_pkg::COLUMNS) ? c.new_col : tcw_pkg::COLUMNS - 1;
                cur_row = (c.new_row < tcw_pkg::ROWS) ? c.new_row : tcw_pkg::ROWS - 1;
                set_cnt++;
            end
            tcw_pkg::ACT_READ:
            begin
                if (c.cell_index < tcw_pkg::CELLS)
                begin
                    r.cell_char = screen_mirror[c.cell_index];
                end
                read_cnt++;
            end
        endcase
        if (r.scrolled)
        begin
            scroll_cnt++;
        end
        r.cursor_index = tcw_pkg::CURSOR_INDEX_W'(cur_row * tcw_pkg::COLUMNS + cur_col);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command builders: unused fields carry random values.
    // ------------------------------------------------------------------
    function automatic console_cmd_t random_cmd(input tcw_pkg::action_t a);
        console_cmd_t c;
        c.action     = a;
        c.char_code  = tcw_pkg::CHAR_W'($urandom_range(255));
        c.new_col    = tcw_pkg::NEW_COL_W'($urandom_range(127));
        c.new_row    = tcw_pkg::NEW_ROW_W'($urandom_range(31));
        c.cell_index = tcw_pkg::CELL_INDEX_W'($urandom_range(2047));
        return c;
    endfunction

    task automatic push_put(input int ch);
        console_cmd_t c;
        c = random_cmd(tcw_pkg::ACT_PUT);
        c.char_code = tcw_pkg::CHAR_W'(ch);
        cmd_pending.push_back(c);
    endtask

    task automatic push_set(input int col, input int row);
        console_cmd_t c;
        c = random_cmd(tcw_pkg::ACT_SET);
        c.new_col = tcw_pkg::NEW_COL_W'(col);
        c.new_row = tcw_pkg::NEW_ROW_W'(row);
        cmd_pending.push_back(c);
    endtask

    task automatic push_read(input int idx);
        console_cmd_t c;
        c = random_cmd(tcw_pkg::ACT_READ);
        c.cell_index = tcw_pkg::CELL_INDEX_W'(idx);
        cmd_pending.push_back(c);
    endtask

    task automatic push_clear();
        cmd_pending.push_back(random_cmd(tcw_pkg::ACT_CLEAR));
    endtask

    function automatic int text_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            return tcw_pkg::CH_NEWLINE;
        end
        if (pick < 23)
        begin
            return tcw_pkg::CH_TAB;
        end
        return $urandom_range(255);
    endfunction

    task automatic build_directed();
        push_read(0);
        push_put(8'h41);
        push_put(8'h00);
        push_put(8'hFF);
        push_put(tcw_pkg::CH_TAB);
        push_put(tcw_pkg::CH_NEWLINE);
        push_set(127, 31);          // clamps to the bottom right cell
        push_put(8'h5A);            // wraps off the last row and scrolls
        push_read(1919);
        push_read(80);
        push_set(76, 0);
        push_put(tcw_pkg::CH_TAB);  // tab reaching the width wraps to row 1
        push_set(78, 24);
        push_put(tcw_pkg::CH_TAB);  // same on the last row scrolls
        push_set(0, 24);
        push_put(tcw_pkg::CH_NEWLINE); // newline on the last row scrolls
        push_read(1999);
        push_read(2000);
        push_read(2047);
        push_set(3, 5);
        push_put(tcw_pkg::CH_TAB);
        push_clear();
        push_read(1919);
        push_set(79, 24);
        push_set(0, 0);
    endtask

    task automatic build_random();
        int pick;
        int col;
        int row;
        int base;
        while (cmd_pending.size() < total_cmds + RANDOM_CMDS)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                // Text run: mostly place the cursor, type a burst, read back near it.
                base = $urandom_range(tcw_pkg::CELLS - 1);
                if ($urandom_range(99) < 80)
                begin
                    if ($urandom_range(99) < 75)
                    begin
                        col = $urandom_range(tcw_pkg::COLUMNS - 1);
                        row = $urandom_range(tcw_pkg::ROWS - 5);
                    end
                    else
                    begin
                        col = $urandom_range(127);
                        row = $urandom_range(31);
                    end
                    push_set(col, row);
                    base = ((row < tcw_pkg::ROWS) ? row : tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS
                         + ((col < tcw_pkg::COLUMNS) ? col : tcw_pkg::COLUMNS - 1);
                end
                repeat ($urandom_range(16, 4))
                begin
                    push_put(text_char());
                end
                repeat ($urandom_range(3, 1))
                begin
                    push_read(base + $urandom_range(20));
                end
            end
            else if (pick < 80)
            begin
                push_read($urandom_range(2047));
            end
            else if (pick < 96)
            begin
                cmd_pending.push_back(random_cmd(tcw_pkg::action_t'($urandom_range(3))));
            end
            else
            begin
                push_clear();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Handshake pressure: three phases over the command stream.
    // ------------------------------------------------------------------
    function automatic int send_idle_pct();
        case (sent_cnt * 3 / total_cmds)
            0:       return 7;
            1:       return 54;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (sent_cnt * 3 / total_cmds)
            0:       return 54;
            1:       return 7;
            default: return 0;
        endcase
    endfunction

    // Command driver.
    always @(posedge clk)
    begin
        console_cmd_t nxt;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
        end
        else if (!cmd_ch.valid || cmd_ch.ready)
        begin
            if (cmd_pending.size() != 0 && $urandom_range(99) >= send_idle_pct())
            begin
                nxt = cmd_pending.pop_front();
                cmd_ch.valid      <= 1'b1;
                cmd_ch.action     <= nxt.action;
                cmd_ch.char_code  <= nxt.char_code;
                cmd_ch.new_col    <= nxt.new_col;
                cmd_ch.new_row    <= nxt.new_row;
                cmd_ch.cell_index <= nxt.cell_index;
                sent_cnt          <= sent_cnt + 1;
            end
            else
            begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Response back-pressure.
    always @(posedge clk)
    begin
        rsp_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct());
    end

    // Monitor: predicts on each command transaction, checks each response transaction.
    always @(posedge clk)
    begin
        console_cmd_t seen;
        console_rsp_t want;
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                seen.action     = tcw_pkg::action_t'(cmd_ch.action);
                seen.char_code  = cmd_ch.char_code;
                seen.new_col    = cmd_ch.new_col;
                seen.new_row    = cmd_ch.new_row;
                seen.cell_index = cmd_ch.cell_index;
                console_rsp_q.push_back(predict_console(seen));
                cmd_acc_cnt++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (console_rsp_q.size() == 0)
                begin
                    report_mismatch("response with no command outstanding");
                end
                else
                begin
                    want = console_rsp_q.pop_front();
                    if (rsp_ch.cursor_index !== want.cursor_index)
                    begin
                        report_mismatch($sformatf("cursor_index got %0d expected %0d",
                                                  rsp_ch.cursor_index, want.cursor_index));
                    end
                    if (rsp_ch.cell_char !== want.cell_char)
                    begin
                        report_mismatch($sformatf("cell_char got 0x%02h expected 0x%02h",
                                                  rsp_ch.cell_char, want.cell_char));
                    end
                    if (rsp_ch.scrolled !== want.scrolled)
                    begin
                        report_mismatch($sformatf("scrolled got %0b expected %0b",
                                                  rsp_ch.scrolled, want.scrolled));
                    end
                end
            end
        end
    end

    // Enough even if every command swept the whole screen under full back-pressure.
    initial
    begin
        #(200_000_000);
        $display("Timeout after %0d of %0d commands accepted", cmd_acc_cnt, total_cmds);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.action     = '0;
        cmd_ch.char_code  = '0;
        cmd_ch.new_col    = '0;
        cmd_ch.new_row    = '0;
        cmd_ch.cell_index = '0;
        rsp_ch.ready      = 1'b0;
        sent_cnt          = 0;
        cmd_acc_cnt       = 0;
        err_cnt           = 0;
        blank_screen();

        build_directed();
        total_cmds = cmd_pending.size();
        build_random();
        total_cmds = cmd_pending.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (!(cmd_acc_cnt == total_cmds && console_rsp_q.size() == 0))
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (console_rsp_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d responses never arrived", console_rsp_q.size()));
        end

        $display("Ran %0d commands: %0d puts, %0d clears, %0d cursor moves, %0d cell reads.",
                 cmd_acc_cnt, put_cnt, clear_cnt, set_cnt, read_cnt);
        $display("The screen scrolled %0d times; %0d mismatches were found.",
                 scroll_cnt, err_cnt);
        if (err_cnt == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
